@@ src/jsu_pkg.sv @@
package jsu_pkg;

    // Number of whole result runs the output queue can hold
    localparam int RUN_DEPTH = 2;

    // Room for all results of one input byte (at most seven), and the widths that follow
    localparam int MAX_RESULTS = 8;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_WAIT    = 3'd0,
        MODE_STR     = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX1    = 3'd3,
        MODE_HIGH    = 3'd4,
        MODE_HIGH_BS = 3'd5,
        MODE_HEX2    = 3'd6
    } t_mode;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERR   = 2'd2
    } t_kind;

    // Error codes; data and close results carry the zero code
    typedef enum logic [2:0] {
        ERR_EXPECTED     = 3'd0,
        ERR_BAD_ESCAPE   = 3'd1,
        ERR_BAD_HEX      = 3'd2,
        ERR_TRUNCATED    = 3'd3,
        ERR_UNTERMINATED = 3'd4
    } t_err;

    // One result
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_err        err;
    } t_result;

    // All results of one input byte, first result in entry 0
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [RES_CNT_W-1:0]      count;
    } t_run;

endpackage

@@ src/jsu_if.sv @@
// Input channel: one byte of JSON text per request
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// Output channel: one decoded result per request
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last_of_run;

    modport source (output valid, output result_kind, output out_byte,
                    output error_code, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input out_byte,
                    input error_code, input last_of_run, output ready);
endinterface

@@ src/jsu_step.sv @@
module jsu_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_byte,
    input  logic           i_fin,
    output jsu_pkg::t_run  o_run
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_utf8;

    // UTF-8 bytes of a code point, first byte in b[0]
    function automatic t_utf8 f_utf8(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp < 21'h80) begin
            r.n    = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.n    = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.n    = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end else begin
            r.n    = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // Scanner state
    jsu_pkg::t_mode r_mode, n_mode;
    logic [2:0]     r_hex_cnt, n_hex_cnt;
    logic [15:0]    r_acc, n_acc;
    logic [15:0]    r_high, n_high;
    logic           r_hex_bad, n_hex_bad;

    // A: held surrogate bytes, B: data bytes, C: close or error
    logic           a_en;
    logic           b_en;
    logic           b_raw;
    logic [7:0]     b_raw_byte;
    logic [20:0]    b_cp;
    logic           c_en;
    jsu_pkg::t_kind c_kind;
    jsu_pkg::t_err  c_err;

    // string-body action
    logic           str_b_en;
    logic           str_c_en;
    jsu_pkg::t_kind str_c_kind;
    jsu_pkg::t_mode str_mode;

    // escape action
    logic           esc_b_en;
    logic [7:0]     esc_byte;
    logic           esc_hex;
    logic           esc_c_en;
    jsu_pkg::t_err  esc_c_err;
    jsu_pkg::t_mode esc_mode;

    // hex digit action
    logic [3:0]     hex_v;
    logic           hex_isbad;
    logic [15:0]    hex_acc;
    logic [2:0]     hex_cnt;
    logic           hex_bad;
    logic           hex_done;
    logic           is_low;
    logic           is_high;

    t_utf8          a_enc;
    t_utf8          b_enc;
    logic [2:0]     na;
    logic [2:0]     nb;
    logic [3:0]     nab;

    // Byte inside a string
    always_comb begin
        str_b_en   = 1'b0;
        str_c_en   = 1'b0;
        str_c_kind = jsu_pkg::KIND_ERR;
        str_mode   = jsu_pkg::MODE_STR;
        if (i_byte == CH_QUOTE) begin
            str_c_en   = 1'b1;
            str_c_kind = jsu_pkg::KIND_CLOSE;
        end else if (i_byte == CH_BSLASH) begin
            str_mode = jsu_pkg::MODE_ESC;
            str_c_en = i_fin;
        end else begin
            str_b_en = 1'b1;
            str_c_en = i_fin;
        end
    end

    // Byte after a backslash
    always_comb begin
        esc_b_en  = 1'b1;
        esc_byte  = i_byte;
        esc_hex   = 1'b0;
        esc_c_en  = i_fin;
        esc_c_err = jsu_pkg::ERR_UNTERMINATED;
        esc_mode  = jsu_pkg::MODE_STR;
        case (i_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = i_byte;
            CH_B: esc_byte = 8'h08;
            CH_F: esc_byte = 8'h0C;
            CH_N: esc_byte = 8'h0A;
            CH_R: esc_byte = 8'h0D;
            CH_T: esc_byte = 8'h09;
            CH_U: begin
                esc_b_en  = 1'b0;
                esc_hex   = 1'b1;
                esc_mode  = jsu_pkg::MODE_HEX1;
                esc_c_err = jsu_pkg::ERR_TRUNCATED;
            end
            default: begin
                esc_b_en  = 1'b0;
                esc_c_en  = 1'b1;
                esc_c_err = jsu_pkg::ERR_BAD_ESCAPE;
            end
        endcase
    end

    // Hex digit value and accumulated code unit
    always_comb begin
        hex_v     = 4'd0;
        hex_isbad = 1'b0;
        if (i_byte inside {[8'h30:8'h39]}) begin
            hex_v = i_byte[3:0];
        end else if (i_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_v = i_byte[3:0] + 4'd9;
        end else begin
            hex_isbad = 1'b1;
        end
    end

    assign hex_acc  = {r_acc[11:0], hex_v};
    assign hex_cnt  = r_hex_cnt + 3'd1;
    assign hex_bad  = r_hex_bad | hex_isbad;
    assign hex_done = hex_cnt[2];
    assign is_low   = (hex_acc[15:10] == 6'b110111);
    assign is_high  = (hex_acc[15:10] == 6'b110110);

    // Mode dispatch and next state
    always_comb begin
        n_mode     = r_mode;
        n_hex_cnt  = r_hex_cnt;
        n_acc      = r_acc;
        n_high     = r_high;
        n_hex_bad  = r_hex_bad;
        a_en       = 1'b0;
        b_en       = 1'b0;
        b_raw      = 1'b0;
        b_raw_byte = i_byte;
        b_cp       = {5'd0, hex_acc};
        c_en       = 1'b0;
        c_kind     = jsu_pkg::KIND_ERR;
        c_err      = jsu_pkg::ERR_UNTERMINATED;

        case (r_mode)
            jsu_pkg::MODE_WAIT: begin
                if (i_byte inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
                    c_en  = i_fin;
                    c_err = jsu_pkg::ERR_EXPECTED;
                end else if (i_byte == CH_QUOTE) begin
                    n_mode = jsu_pkg::MODE_STR;
                    c_en   = i_fin;
                end else begin
                    c_en  = 1'b1;
                    c_err = jsu_pkg::ERR_EXPECTED;
                end
            end
            jsu_pkg::MODE_STR: begin
                b_en   = str_b_en;
                b_raw  = 1'b1;
                c_en   = str_c_en;
                c_kind = str_c_kind;
                n_mode = str_mode;
            end
            jsu_pkg::MODE_ESC: begin
                b_en       = esc_b_en;
                b_raw      = 1'b1;
                b_raw_byte = esc_byte;
                c_en       = esc_c_en;
                c_err      = esc_c_err;
                n_mode     = esc_mode;
                if (esc_hex) begin
                    n_hex_cnt = 3'd0;
                    n_acc     = 16'd0;
                    n_hex_bad = 1'b0;
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                n_acc     = hex_acc;
                n_hex_cnt = hex_cnt;
                n_hex_bad = hex_bad;
                if (!hex_done) begin
                    c_en  = i_fin;
                    c_err = jsu_pkg::ERR_TRUNCATED;
                end else if (hex_bad) begin
                    c_en  = 1'b1;
                    c_err = jsu_pkg::ERR_BAD_HEX;
                end else begin
                    n_hex_cnt = 3'd0;
                    n_acc     = 16'd0;
                    if (r_mode == jsu_pkg::MODE_HEX2 && is_low) begin
                        // surrogate pair: one 4-byte character
                        b_en   = 1'b1;
                        b_cp   = 21'h010000 + {1'b0, r_high[9:0], hex_acc[9:0]};
                        n_high = 16'd0;
                        n_mode = jsu_pkg::MODE_STR;
                        c_en   = i_fin;
                    end else begin
                        // unpaired held surrogate goes out first
                        if (r_mode == jsu_pkg::MODE_HEX2) begin
                            a_en   = 1'b1;
                            n_high = 16'd0;
                        end
                        if (is_high && !i_fin) begin
                            n_high = hex_acc;
                            n_mode = jsu_pkg::MODE_HIGH;
                        end else begin
                            b_en   = 1'b1;
                            n_high = 16'd0;
                            n_mode = jsu_pkg::MODE_STR;
                            c_en   = i_fin;
                        end
                    end
                end
            end
            jsu_pkg::MODE_HIGH: begin
                if (i_byte == CH_BSLASH && !i_fin) begin
                    n_mode = jsu_pkg::MODE_HIGH_BS;
                end else begin
                    a_en   = 1'b1;
                    n_high = 16'd0;
                    b_en   = str_b_en;
                    b_raw  = 1'b1;
                    c_en   = str_c_en;
                    c_kind = str_c_kind;
                    n_mode = str_mode;
                end
            end
            jsu_pkg::MODE_HIGH_BS: begin
                if (i_byte == CH_U) begin
                    n_mode    = jsu_pkg::MODE_HEX2;
                    n_hex_cnt = 3'd0;
                    n_acc     = 16'd0;
                    n_hex_bad = 1'b0;
                    c_en      = i_fin;
                    c_err     = jsu_pkg::ERR_TRUNCATED;
                end else begin
                    a_en       = 1'b1;
                    n_high     = 16'd0;
                    b_en       = esc_b_en;
                    b_raw      = 1'b1;
                    b_raw_byte = esc_byte;
                    c_en       = esc_c_en;
                    c_err      = esc_c_err;
                    n_mode     = esc_mode;
                end
            end
            default: begin
                n_mode = jsu_pkg::MODE_WAIT;
            end
        endcase

        // close, errors and bytes that keep it waiting leave the scanner in its reset state
        if (c_en || r_mode == jsu_pkg::MODE_WAIT && n_mode == jsu_pkg::MODE_WAIT) begin
            n_mode    = jsu_pkg::MODE_WAIT;
            n_hex_cnt = 3'd0;
            n_acc     = 16'd0;
            n_high    = 16'd0;
            n_hex_bad = 1'b0;
        end
    end

    // Encoders for the held surrogate and for the data part
    assign a_enc = f_utf8({5'd0, r_high});

    always_comb begin
        if (b_raw) begin
            b_enc      = '0;
            b_enc.n    = 3'd1;
            b_enc.b[0] = b_raw_byte;
        end else begin
            b_enc = f_utf8(b_cp);
        end
    end

    assign na  = a_en ? a_enc.n : 3'd0;
    assign nb  = b_en ? b_enc.n : 3'd0;
    assign nab = {1'b0, na} + {1'b0, nb};

    // Lay out the run: held surrogate, data bytes, then close or error
    always_comb begin
        logic [3:0] idx;
        logic [3:0] j;
        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
            idx = 4'(i);
            j   = idx - {1'b0, na};
            o_run.res[i] = '0;
            if (idx < {1'b0, na}) begin
                o_run.res[i].kind = jsu_pkg::KIND_DATA;
                o_run.res[i].data = a_enc.b[idx[1:0]];
            end else if (idx < nab) begin
                o_run.res[i].kind = jsu_pkg::KIND_DATA;
                o_run.res[i].data = b_enc.b[j[1:0]];
            end else if (idx == nab && c_en) begin
                o_run.res[i].kind = c_kind;
                o_run.res[i].err  = (c_kind == jsu_pkg::KIND_ERR) ? c_err
                                                                 : jsu_pkg::ERR_EXPECTED;
            end
        end
        o_run.count = jsu_pkg::RES_CNT_W'(nab + {3'd0, c_en});
    end

    // State registers advance once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_WAIT;
            r_hex_cnt <= 3'd0;
            r_acc     <= 16'd0;
            r_high    <= 16'd0;
            r_hex_bad <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_acc     <= n_acc;
            r_high    <= n_high;
            r_hex_bad <= n_hex_bad;
        end
    end

`ifndef SYNTHESIS
    a_hex_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hex_cnt[2])
        else $error("hex digit count reached four without completing");

    a_held_is_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == jsu_pkg::MODE_HIGH || r_mode == jsu_pkg::MODE_HIGH_BS ||
         r_mode == jsu_pkg::MODE_HEX2) |-> (r_high[15:10] == 6'b110110))
        else $error("held code unit is not a high surrogate");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && c_en) |=> (r_mode == jsu_pkg::MODE_WAIT && r_high == 16'd0))
        else $error("scanner state not cleared after close or error");
`endif

endmodule

@@ src/jsu_run_fifo.sv @@
module jsu_run_fifo #(
    parameter int P_DEPTH = jsu_pkg::RUN_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jsu_pkg::t_run    i_run,
    output logic             o_full,
    jsu_out_if.source        o_out
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    jsu_pkg::t_run                    r_mem [P_DEPTH];
    logic [AW-1:0]                    r_wr;
    logic [AW-1:0]                    r_rd;
    logic [CW-1:0]                    r_used;
    logic [jsu_pkg::RES_IDX_W-1:0]    r_idx;

    jsu_pkg::t_run   head;
    jsu_pkg::t_result cur;
    logic            last;
    logic            pop_item;
    logic            pop_run;

    // Head run and the result within it
    assign head = r_mem[r_rd];
    assign cur  = head.res[r_idx];
    assign last = (jsu_pkg::RES_CNT_W'(r_idx) + jsu_pkg::RES_CNT_W'(1)) == head.count;

    assign o_full            = (r_used == CW'(P_DEPTH));
    assign o_out.valid       = (r_used != '0);
    assign o_out.result_kind = cur.kind;
    assign o_out.out_byte    = cur.data;
    assign o_out.error_code  = cur.err;
    assign o_out.last_of_run = last;

    assign pop_item = o_out.valid && o_out.ready;
    assign pop_run  = pop_item && last;

    // Run storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    // Pointers, fill level and position within the head run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_used <= '0;
            r_idx  <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop_run) begin
                r_rd  <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + AW'(1);
                r_idx <= '0;
            end else if (pop_item) begin
                r_idx <= r_idx + jsu_pkg::RES_IDX_W'(1);
            end
            r_used <= r_used + CW'(i_push) - CW'(pop_run);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("run pushed into a full queue");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (head.count != '0))
        else $error("empty run stored in queue");

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (jsu_pkg::RES_CNT_W'(r_idx) < head.count))
        else $error("result index beyond end of head run");
`endif

endmodule

@@ src/json_string_unescape_utf8_core.sv @@
// Streaming JSON string unescaper: takes JSON text one byte per request and
// returns the UTF-8 bytes of one string literal, then a close result (or an
// error result), one result per request. An accepted byte sits in an input
// register and is decoded from it once its results have room; its results
// (up to seven) are then written as one run into a small run queue, from
// which the first result is offered. A byte is taken every cycle as long as
// a run slot is free, so the input sustains one byte per cycle while each
// byte yields at most one result on average; the output port drains one
// result per cycle while its ready is high, so a byte that causes N results
// holds the output until all N are taken and the sustained input rate is set
// by that port. Bytes that cause no result (whitespace, backslash, hex digits)
// never occupy the queue. last_of_run marks the final result caused by a byte.
module json_string_unescape_utf8_core #(
    parameter int P_RUN_DEPTH = jsu_pkg::RUN_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_fin;

    jsu_pkg::t_run w_run;
    logic          w_full;
    logic          w_step;
    logic          w_push;

    // Decode the held byte when its results have room
    assign w_step     = r_in_valid && ((w_run.count == '0) || !w_full);
    assign w_push     = w_step && (w_run.count != '0);
    assign i_in.ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.text_byte;
            r_in_fin  <= i_in.final_byte;
        end
    end

    jsu_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_fin   (r_in_fin),
        .o_run   (w_run)
    );

    jsu_run_fifo #(
        .P_DEPTH (P_RUN_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_run),
        .o_full  (w_full),
        .o_out   (o_out)
    );

endmodule

@@ tb/testbench.sv @@
module testbench;

    // JSON characters the decoder cares about
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int RANDOM_BYTES = 100;
    localparam int TAIL_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [7:0] b;
        bit         fin;
    } t_text_item;

    typedef struct {
        jsu_pkg::t_kind kind;
        logic [7:0]     data;
        jsu_pkg::t_err  err;
        bit             last;
    } t_decoded;

    logic clk   = 1'b1;
    logic rst_n = 1'b0;

    jsu_in_if  in_bus ();
    jsu_out_if out_bus ();

    json_string_unescape_utf8_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #5 clk = 1'b0;
        #5 clk = 1'b1;
    end

    t_text_item text_q[$];
    t_decoded   pending_results[$];
    t_decoded   run_q[$];
    int         fail_count = 0;
    bit         in_took    = 1'b0;
    int         in_gap     = 0;
    int         out_gap    = 0;

    // Decoder state mirror
    jsu_pkg::t_mode sc_mode;
    logic [2:0]     sc_digits;
    logic [15:0]    sc_acc;
    logic [15:0]    sc_high;
    bit             sc_hex_bad;

    function automatic void clear_scan();
        sc_mode    = jsu_pkg::MODE_WAIT;
        sc_digits  = '0;
        sc_acc     = '0;
        sc_high    = '0;
        sc_hex_bad = 1'b0;
    endfunction

    function automatic void put_result(jsu_pkg::t_kind k, logic [7:0] d, jsu_pkg::t_err e);
        t_decoded r;
        if (run_q.size() >= jsu_pkg::MAX_RESULTS) return;
        r.kind = k;
        r.data = d;
        r.err  = e;
        r.last = 1'b0;
        run_q = {run_q, r};
    endfunction

    function automatic void put_data(logic [7:0] d);
        put_result(jsu_pkg::KIND_DATA, d, jsu_pkg::ERR_EXPECTED);
    endfunction

    function automatic void raise_error(jsu_pkg::t_err e);
        put_result(jsu_pkg::KIND_ERR, 8'h00, e);
        clear_scan();
    endfunction

    function automatic void put_utf8(logic [20:0] cp);
        if (cp < 21'h80) begin
            put_data(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_data({3'b110, cp[10:6]});
            put_data({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            put_data({4'b1110, cp[15:12]});
            put_data({2'b10, cp[11:6]});
            put_data({2'b10, cp[5:0]});
        end else begin
            put_data({5'b11110, cp[20:18]});
            put_data({2'b10, cp[17:12]});
            put_data({2'b10, cp[11:6]});
            put_data({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void start_hex(jsu_pkg::t_mode m, bit fin);
        sc_mode    = m;
        sc_digits  = '0;
        sc_acc     = '0;
        sc_hex_bad = 1'b0;
        if (fin) raise_error(jsu_pkg::ERR_TRUNCATED);
    endfunction

    // complete code point: hold a high surrogate unless the text ends, else encode it
    function automatic void finish_cp(logic [15:0] cp, bit fin);
        if (cp >= 16'hD800 && cp <= 16'hDBFF && !fin) begin
            sc_high = cp;
            sc_mode = jsu_pkg::MODE_HIGH;
            return;
        end
        put_utf8({5'b0, cp});
        sc_high = '0;
        sc_mode = jsu_pkg::MODE_STR;
        if (fin) raise_error(jsu_pkg::ERR_UNTERMINATED);
    endfunction

    function automatic void string_byte(logic [7:0] b, bit fin);
        if (b == CH_QUOTE) begin
            put_result(jsu_pkg::KIND_CLOSE, 8'h00, jsu_pkg::ERR_EXPECTED);
            clear_scan();
        end else if (b == CH_BSLASH) begin
            if (fin) raise_error(jsu_pkg::ERR_UNTERMINATED);
            else sc_mode = jsu_pkg::MODE_ESC;
        end else begin
            put_data(b);
            sc_mode = jsu_pkg::MODE_STR;
            if (fin) raise_error(jsu_pkg::ERR_UNTERMINATED);
        end
    endfunction

    function automatic void escape_byte(logic [7:0] b, bit fin);
        logic [7:0] m;
        case (b)
            CH_QUOTE:  m = CH_QUOTE;
            CH_BSLASH: m = CH_BSLASH;
            CH_SLASH:  m = CH_SLASH;
            CH_B:      m = 8'h08;
            CH_F:      m = 8'h0C;
            CH_N:      m = 8'h0A;
            CH_R:      m = 8'h0D;
            CH_T:      m = 8'h09;
            CH_U: begin
                start_hex(jsu_pkg::MODE_HEX1, fin);
                return;
            end
            default: begin
                raise_error(jsu_pkg::ERR_BAD_ESCAPE);
                return;
            end
        endcase
        put_data(m);
        sc_mode = jsu_pkg::MODE_STR;
        if (fin) raise_error(jsu_pkg::ERR_UNTERMINATED);
    endfunction

    function automatic void hex_byte(logic [7:0] b, bit fin);
        logic [3:0]  v;
        logic [15:0] cp;
        logic [15:0] hi;
        logic [20:0] pair;
        v = 4'h0;
        if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h37);
        else sc_hex_bad = 1'b1;
        sc_acc    = {sc_acc[11:0], v};
        sc_digits = sc_digits + 3'd1;
        if (sc_digits < 3'd4) begin
            if (fin) raise_error(jsu_pkg::ERR_TRUNCATED);
            return;
        end
        if (sc_hex_bad) begin
            raise_error(jsu_pkg::ERR_BAD_HEX);
            return;
        end
        cp        = sc_acc;
        sc_digits = '0;
        sc_acc    = '0;
        if (sc_mode == jsu_pkg::MODE_HEX2) begin
            hi = sc_high;
            // low surrogate completes the pair
            if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                pair = 21'h10000 + ({11'b0, hi[9:0]} << 10) + {11'b0, cp[9:0]};
                put_utf8(pair);
                sc_high = '0;
                sc_mode = jsu_pkg::MODE_STR;
                if (fin) raise_error(jsu_pkg::ERR_UNTERMINATED);
                return;
            end
            put_utf8({5'b0, hi});
            sc_high = '0;
        end
        finish_cp(cp, fin);
    endfunction

    // Expected results of one accepted text byte
    function automatic void decode_byte(logic [7:0] b, bit fin);
        run_q.delete();
        case (sc_mode)
            jsu_pkg::MODE_WAIT: begin
                if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
                    if (fin) raise_error(jsu_pkg::ERR_EXPECTED);
                end else if (b == CH_QUOTE) begin
                    sc_mode = jsu_pkg::MODE_STR;
                    if (fin) raise_error(jsu_pkg::ERR_UNTERMINATED);
                end else begin
                    raise_error(jsu_pkg::ERR_EXPECTED);
                end
            end
            jsu_pkg::MODE_STR:  string_byte(b, fin);
            jsu_pkg::MODE_ESC:  escape_byte(b, fin);
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: hex_byte(b, fin);
            jsu_pkg::MODE_HIGH: begin
                if (b == CH_BSLASH && !fin) begin
                    sc_mode = jsu_pkg::MODE_HIGH_BS;
                end else begin
                    put_utf8({5'b0, sc_high});
                    sc_high = '0;
                    sc_mode = jsu_pkg::MODE_STR;
                    string_byte(b, fin);
                end
            end
            jsu_pkg::MODE_HIGH_BS: begin
                if (b == CH_U) begin
                    start_hex(jsu_pkg::MODE_HEX2, fin);
                end else begin
                    put_utf8({5'b0, sc_high});
                    sc_high = '0;
                    sc_mode = jsu_pkg::MODE_STR;
                    escape_byte(b, fin);
                end
            end
            default: clear_scan();
        endcase
        if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
        pending_results = {pending_results, run_q};
    endfunction

    // Stimulus helpers
    task automatic push_byte(logic [7:0] b, bit fin);
        t_text_item t;
        t.b   = b;
        t.fin = fin;
        text_q = {text_q, t};
    endtask

    task automatic push_text(string s, bit fin_end);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], fin_end && (i == s.len() - 1));
    endtask

    // random bytes are sometimes marked as the end of the text
    task automatic push_rand(logic [7:0] b);
        push_byte(b, $urandom_range(0, 49) == 0);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] d, bit upper);
        if (d < 4'd10) return 8'h30 + {4'h0, d};
        return (upper ? 8'h37 : 8'h57) + {4'h0, d};
    endfunction

    function automatic bit is_hex(logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic bit is_escape_char(logic [7:0] b);
        return b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
               b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U;
    endfunction

    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            3: return 16'($urandom_range(16'hD800, 16'hDBFF));
            4: return 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_u_escape(logic [15:0] v);
        push_rand(CH_BSLASH);
        push_rand(CH_U);
        for (int i = 3; i >= 0; i--)
            push_rand(hex_char(v[4*i +: 4], 1'($urandom_range(0, 1))));
    endtask

    // mostly well-formed literals, with noise and broken escapes mixed in
    task automatic push_literal();
        logic [7:0] b;
        int         pos;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) push_rand(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: push_rand(CH_SPACE);
                1: push_rand(CH_TAB);
                2: push_rand(CH_LF);
                default: push_rand(CH_CR);
            endcase
        end
        push_rand(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: begin
                    b = 8'($urandom);
                    if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
                    push_rand(b);
                end
                4: begin
                    push_rand(CH_BSLASH);
                    case ($urandom_range(0, 7))
                        0: push_rand(CH_QUOTE);
                        1: push_rand(CH_BSLASH);
                        2: push_rand(CH_SLASH);
                        3: push_rand(CH_B);
                        4: push_rand(CH_F);
                        5: push_rand(CH_N);
                        6: push_rand(CH_R);
                        default: push_rand(CH_T);
                    endcase
                end
                5: push_u_escape(pick_code_point());
                6: begin
                    push_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                    push_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                default: begin
                    push_rand(CH_BSLASH);
                    if ($urandom_range(0, 1) == 0) begin
                        b = 8'($urandom);
                        if (is_escape_char(b)) b = 8'h71;
                        push_rand(b);
                    end else begin
                        // one digit position holds a non-hex byte
                        pos = $urandom_range(0, 3);
                        push_rand(CH_U);
                        for (int i = 0; i < 4; i++) begin
                            if (i == pos) begin
                                b = 8'($urandom);
                                if (is_hex(b)) b = 8'h78;
                                push_rand(b);
                            end else begin
                                push_rand(hex_char(4'($urandom),
                                                   1'($urandom_range(0, 1))));
                            end
                        end
                    end
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0) push_rand(CH_QUOTE);
    endtask

    function automatic bit tail_phase();
        return text_q.size() < TAIL_ITEMS;
    endfunction

    // Sample both channels; predict requests, check results
    always @(posedge clk) begin
        t_decoded w;
        in_took <= rst_n && in_bus.valid && in_bus.ready;
        if (rst_n && in_bus.valid && in_bus.ready)
            decode_byte(in_bus.text_byte, in_bus.final_byte);
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: kind %0d byte %h err %0d last %0d", $time,
                         out_bus.result_kind, out_bus.out_byte, out_bus.error_code,
                         out_bus.last_of_run);
                fail_count++;
            end else begin
                w = pending_results.pop_front();
                if (out_bus.result_kind !== w.kind || out_bus.out_byte !== w.data ||
                    out_bus.error_code !== w.err || out_bus.last_of_run !== w.last) begin
                    $display({"%0t: mismatch: expected kind %0d byte %h err %0d last %0d,",
                              " got kind %0d byte %h err %0d last %0d"},
                             $time, w.kind, w.data, w.err, w.last, out_bus.result_kind,
                             out_bus.out_byte, out_bus.error_code, out_bus.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Request driver with idle bursts between requests
    always @(negedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_took) void'(text_q.pop_front());
            if (in_gap != 0) begin
                in_gap--;
                in_bus.valid <= 1'b0;
            end else if (!in_bus.valid || in_took) begin
                if (text_q.size() == 0) begin
                    in_bus.valid <= 1'b0;
                end else if (!tail_phase() && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 4);
                    in_bus.valid <= 1'b0;
                end else begin
                    in_bus.valid      <= 1'b1;
                    in_bus.text_byte  <= text_q[0].b;
                    in_bus.final_byte <= text_q[0].fin;
                end
            end
        end
    end

    // Result-side back-pressure
    always @(negedge clk) begin
        if (out_gap != 0) begin
            out_gap--;
            out_bus.ready <= 1'b0;
        end else if (!tail_phase() && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 4);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    initial begin
        int goal;
        in_bus.valid      = 1'b0;
        in_bus.text_byte  = 8'h00;
        in_bus.final_byte = 1'b0;
        out_bus.ready     = 1'b0;
        clear_scan();

        // Directed: whitespace, every simple escape, close
        push_byte(CH_SPACE, 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(CH_CR, 1'b0);
        push_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
        // not a quote, then final whitespace
        push_text("x", 1'b0);
        push_byte(CH_SPACE, 1'b1);
        // 1, 2 and 3 byte encodings, surrogate pair
        push_text("\"\\u0041\\u00e9\\u20AC\"", 1'b0);
        push_text("\"\\uD83D\\uDE00\"", 1'b0);
        // lone high surrogate before plain byte, simple escape, close, new high
        push_text("\"\\uD800x\"", 1'b0);
        push_text("\"\\uDBFF\\uD801\\uDC00\"", 1'b0);
        push_text("\"\\uD800\\n\"", 1'b0);
        push_text("\"\\uD800\"", 1'b0);
        push_text("\"\\uD800\\q", 1'b0);
        // bad hex, and text end inside the escape
        push_text("\"\\uZZ12", 1'b0);
        push_text("\"\\uZ2", 1'b1);
        push_text("\"\\u", 1'b1);
        push_text("\"\\", 1'b1);
        push_text("\"ab", 1'b1);
        push_text("\"", 1'b1);
        // text end around a held surrogate
        push_text("\"\\uD800\\", 1'b1);
        push_text("\"\\uD800", 1'b1);
        push_text("\"\\uD800a", 1'b1);
        push_text("\"\\uD800\\u", 1'b1);
        push_text("\"\\uD800\\uD800", 1'b1);
        // byte extremes and code point extremes
        push_byte(CH_QUOTE, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CH_QUOTE, 1'b0);
        push_text("\"\\uDFFF\\uffff\\u0000\\u07FF\\u0800\\uDBFF\\uDFFF\"", 1'b0);

        goal = text_q.size() + RANDOM_BYTES;
        while (text_q.size() < goal) push_literal();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
src/jsu_pkg.sv
src/jsu_if.sv
src/jsu_step.sv
src/jsu_run_fifo.sv
src/json_string_unescape_utf8_core.sv
tb/testbench.sv
